// ----- design/fce_pkg.sv -----
// Shared types and constants for the frame cadence estimator.
`default_nettype none

package fce_pkg;

  // Field widths of the timing inputs and count outputs.
  localparam int unsigned TimeW = 22;
  localparam int unsigned HystW = 20;
  localparam int unsigned MinW  = 40;
  localparam int unsigned CntW  = 8;

  // Configuration register indexes.
  localparam logic RegMinDrift = 1'b0;
  localparam logic RegHyst     = 1'b1;

  // Request commands.
  localparam logic CmdUpdate = 1'b0;
  localparam logic CmdClear  = 1'b1;

  typedef enum logic [1:0] {
    CAD_NONE   = 2'd0,
    CAD_REPEAT = 2'd1,
    CAD_KEEP   = 2'd2,
    CAD_TWO    = 2'd3
  } cadence_e;

  typedef enum logic [1:0] {
    CAND_REPEAT = 2'd0,
    CAND_KEEP   = 2'd1,
    CAND_TWO    = 2'd2
  } cand_e;

endpackage

`default_nettype wire

// ----- design/fce_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module fce_div #(
  parameter int unsigned W = 33
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  quo_q, rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [W:0]    shift_w, diff_w;
  logic          take_w;

  assign shift_w = {rem_q, quo_q[W-1]};
  assign diff_w  = shift_w - {1'b0, den_q};
  assign take_w  = shift_w >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q <= num_i;
        rem_q <= '0;
        den_q <= den_i;
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= take_w ? diff_w[W-1:0] : shift_w[W-1:0];
        quo_q <= {quo_q[W-2:0], take_w};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ----- design/frame_cadence_estimator.sv -----
// Frame cadence estimator top level: sequencer, serial divider and multiplier, cadence state.
//
//   channel   direction  signals
//   in        request    in_valid_i / in_ready_o, command, interval, duration, drift
//   out       result     out_valid_o / out_ready_i, changed, kind, counts
//   cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// One request at a time. Each tried candidate is paced by the bit-serial
// divider (DW = 33 at defaults) and the 22-step shift-add multiplier; a clear
// skips the candidates and goes straight to the result.
// A finished result waits in the output register; the next request is taken
// while it waits, and the block stalls only at the end of that next request.
// Reset clears the cadence state and loads the register defaults.
`default_nettype none

module frame_cadence_estimator
  import fce_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_COUNT = 255
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [MinW-1:0]  cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             command_i,
  input  wire logic [TimeW-1:0] render_interval_us_i,
  input  wire logic [TimeW-1:0] frame_duration_us_i,
  input  wire logic [TimeW-1:0] max_drift_us_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  changed_o,
  output logic [1:0]            cadence_kind_o,
  output logic [CntW-1:0]       count_first_o,
  output logic [CntW-1:0]       count_second_o
);

  localparam int unsigned CW  = $clog2(MAX_PATTERN_COUNT + 1);
  localparam int unsigned FW  = (CW > CntW) ? CW : CntW;
  localparam int unsigned NW  = CW + 1;
  localparam int unsigned RW  = NW + TimeW + 1;
  localparam int unsigned DW  = RW + 1;
  localparam int unsigned PW  = RW + TimeW;
  localparam int unsigned MCW = $clog2(TimeW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RSET, ST_RDIV, ST_MUL1, ST_DLT, ST_FDIV, ST_MUL2,
    ST_FCHK, ST_NEXT, ST_PICK, ST_HYS, ST_HMUL, ST_HCHK, ST_FIN
  } state_e;

  state_e           state_q;
  cand_e            cand_q;
  logic [TimeW-1:0] ri_q, fd_q, drift_q;
  logic [MinW-1:0]  min_q;
  logic [HystW-1:0] hyst_q, hold_q;
  logic [NW-1:0]    n_q;
  logic [RW-1:0]    rend_q;
  logic [PW-1:0]    acc_q, mcand_q;
  logic [TimeW-1:0] mplier_q;
  logic [MCW-1:0]   mcnt_q;
  cadence_e         ck_q, cur_kind_q, pend_kind_q;
  logic [FW-1:0]    cf_q, cs_q, cur_first_q, cur_second_q, pend_first_q, pend_second_q;
  logic             chg_q;
  logic             out_valid_q, out_chg_q;
  logic [1:0]       out_kind_q;
  logic [CntW-1:0]  out_first_q, out_second_q;

  // Divider hookup
  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_den, quot;

  logic [TimeW:0] x_w;
  logic [TimeW-1:0] y_w;
  logic [DW-1:0] rnum_w, rden_w;
  logic          q_ok;
  logic [RW-1:0] rend_w, act_w, delta_w;
  logic          mul_run, mul_last;
  logic          eq_cur, eq_pend;
  logic [HystW-1:0] hold_inc;
  logic          in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    unique case (cand_q)
      CAND_KEEP: begin
        x_w = {1'b0, ri_q};
        y_w = fd_q;
      end
      CAND_TWO: begin
        x_w = {fd_q, 1'b0};
        y_w = ri_q;
      end
      default: begin
        x_w = {1'b0, fd_q};
        y_w = ri_q;
      end
    endcase
  end

  assign rnum_w = DW'({x_w, 1'b0}) + DW'(y_w);
  assign rden_w = DW'({y_w, 1'b0});

  assign q_ok = (quot != '0) &&
                ((cand_q == CAND_TWO) ? (quot <= DW'(2 * MAX_PATTERN_COUNT))
                                      : (quot <= DW'(MAX_PATTERN_COUNT)));

  always_comb begin
    unique case (cand_q)
      CAND_KEEP: begin
        rend_w = RW'(ri_q);
        act_w  = acc_q[RW-1:0];
      end
      CAND_TWO: begin
        rend_w = acc_q[RW-1:0];
        act_w  = RW'({fd_q, 1'b0});
      end
      default: begin
        rend_w = acc_q[RW-1:0];
        act_w  = RW'(fd_q);
      end
    endcase
  end

  assign delta_w = (rend_w > act_w) ? (rend_w - act_w) : (act_w - rend_w);

  always_comb begin
    div_start = 1'b0;
    div_num   = rnum_w;
    div_den   = rden_w;
    if (state_q == ST_RSET) begin
      div_start = (y_w != '0);
    end else if (state_q == ST_DLT) begin
      div_start = (rend_w != act_w);
      div_num   = DW'(drift_q) + DW'(delta_w) - DW'(1);
      div_den   = DW'(delta_w);
    end
  end

  fce_div #(.W(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign mul_run  = (state_q == ST_MUL1) || (state_q == ST_MUL2) || (state_q == ST_HMUL);
  assign mul_last = (mcnt_q == MCW'(TimeW - 1));

  assign eq_cur  = (ck_q == cur_kind_q) && (cf_q == cur_first_q) && (cs_q == cur_second_q);
  assign eq_pend = (ck_q == pend_kind_q) && (cf_q == pend_first_q) &&
                   (cs_q == pend_second_q);
  assign hold_inc = (hold_q == '1) ? hold_q : hold_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cand_q        <= CAND_REPEAT;
      ri_q          <= '0;
      fd_q          <= '0;
      drift_q       <= '0;
      min_q         <= MinW'(10000000);
      hyst_q        <= HystW'(100000);
      hold_q        <= '0;
      n_q           <= '0;
      rend_q        <= '0;
      acc_q         <= '0;
      mcand_q       <= '0;
      mplier_q      <= '0;
      mcnt_q        <= '0;
      ck_q          <= CAD_NONE;
      cf_q          <= '0;
      cs_q          <= '0;
      cur_kind_q    <= CAD_NONE;
      cur_first_q   <= '0;
      cur_second_q  <= '0;
      pend_kind_q   <= CAD_NONE;
      pend_first_q  <= '0;
      pend_second_q <= '0;
      chg_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      out_chg_q     <= 1'b0;
      out_kind_q    <= '0;
      out_first_q   <= '0;
      out_second_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMinDrift) begin
          min_q <= cfg_data_i;
        end else begin
          hyst_q <= cfg_data_i[HystW-1:0];
        end
      end

      // Drop the result once taken, unless a new one loads in this cycle.
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      if (mul_run) begin
        acc_q    <= acc_q + (mplier_q[0] ? mcand_q : '0);
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        mcnt_q   <= mcnt_q + 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ri_q    <= render_interval_us_i;
            fd_q    <= frame_duration_us_i;
            drift_q <= max_drift_us_i;
            cand_q  <= CAND_REPEAT;
            chg_q   <= 1'b0;
            if (command_i == CmdClear) begin
              cur_kind_q    <= CAD_NONE;
              cur_first_q   <= '0;
              cur_second_q  <= '0;
              pend_kind_q   <= CAD_NONE;
              pend_first_q  <= '0;
              pend_second_q <= '0;
              hold_q        <= '0;
              state_q       <= ST_FIN;
            end else begin
              state_q <= ST_RSET;
            end
          end
        end
        ST_RSET: begin
          // Zero divisor rounds to zero: drop this candidate.
          state_q <= (y_w != '0) ? ST_RDIV : ST_NEXT;
        end
        ST_RDIV: begin
          if (div_done) begin
            if (q_ok) begin
              n_q      <= quot[NW-1:0];
              mcand_q  <= PW'(quot[NW-1:0]);
              mplier_q <= (cand_q == CAND_KEEP) ? fd_q : ri_q;
              acc_q    <= '0;
              mcnt_q   <= '0;
              state_q  <= ST_MUL1;
            end else begin
              state_q <= ST_NEXT;
            end
          end
        end
        ST_MUL1: begin
          if (mul_last) begin
            state_q <= ST_DLT;
          end
        end
        ST_DLT: begin
          rend_q  <= rend_w;
          state_q <= (rend_w == act_w) ? ST_PICK : ST_FDIV;
        end
        ST_FDIV: begin
          if (div_done) begin
            mcand_q  <= PW'(rend_q);
            mplier_q <= quot[TimeW-1:0];
            acc_q    <= '0;
            mcnt_q   <= '0;
            state_q  <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (mul_last) begin
            state_q <= ST_FCHK;
          end
        end
        ST_FCHK: begin
          state_q <= (acc_q >= PW'(min_q)) ? ST_PICK : ST_NEXT;
        end
        ST_NEXT: begin
          if (cand_q == CAND_TWO) begin
            ck_q    <= CAD_NONE;
            cf_q    <= '0;
            cs_q    <= '0;
            state_q <= ST_HYS;
          end else begin
            cand_q  <= (cand_q == CAND_REPEAT) ? CAND_KEEP : CAND_TWO;
            state_q <= ST_RSET;
          end
        end
        ST_PICK: begin
          cs_q <= '0;
          unique case (cand_q)
            CAND_REPEAT: begin
              ck_q <= CAD_REPEAT;
              cf_q <= FW'(n_q);
            end
            CAND_KEEP: begin
              ck_q <= (n_q == NW'(1)) ? CAD_REPEAT : CAD_KEEP;
              cf_q <= FW'(n_q);
            end
            default: begin
              // Even r repeats r/2; r of one is keep 1 of 2.
              if (!n_q[0]) begin
                ck_q <= CAD_REPEAT;
                cf_q <= FW'(n_q >> 1);
              end else if (n_q == NW'(1)) begin
                ck_q <= CAD_KEEP;
                cf_q <= FW'(2);
              end else begin
                ck_q <= CAD_TWO;
                cf_q <= FW'(n_q >> 1) + FW'(1);
                cs_q <= FW'(n_q >> 1);
              end
            end
          endcase
          state_q <= ST_HYS;
        end
        ST_HYS: begin
          if (eq_cur) begin
            hold_q  <= '0;
            state_q <= ST_FIN;
          end else if (eq_pend || ({2'b00, hyst_q} <= ri_q)) begin
            hold_q   <= hold_inc;
            mcand_q  <= PW'(hold_inc);
            mplier_q <= ri_q;
            acc_q    <= '0;
            mcnt_q   <= '0;
            state_q  <= ST_HMUL;
          end else begin
            pend_kind_q   <= ck_q;
            pend_first_q  <= cf_q;
            pend_second_q <= cs_q;
            hold_q        <= HystW'(1);
            state_q       <= ST_FIN;
          end
        end
        ST_HMUL: begin
          if (mul_last) begin
            state_q <= ST_HCHK;
          end
        end
        ST_HCHK: begin
          if (acc_q >= PW'(hyst_q)) begin
            cur_kind_q   <= ck_q;
            cur_first_q  <= cf_q;
            cur_second_q <= cs_q;
            chg_q        <= 1'b1;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // Hold until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_chg_q    <= chg_q;
            out_kind_q   <= cur_kind_q;
            out_first_q  <= cur_first_q[CntW-1:0];
            out_second_q <= cur_second_q[CntW-1:0];
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign changed_o      = out_chg_q;
  assign cadence_kind_o = out_kind_q;
  assign count_first_o  = out_first_q;
  assign count_second_o = out_second_q;

endmodule

`default_nettype wire
